### rtl/core/sbp_pkg.sv
// sbp_pkg: shared constants and types for the swept box push-out block
// depends on nothing
`timescale 1ns / 1ps
package sbp_pkg;

  // default coordinate width (signed Q16.16)
  localparam int COORD_BITS = 32;

  // pushed face codes
  localparam logic [2:0] FACE_NONE   = 3'd0;
  localparam logic [2:0] FACE_TOP    = 3'd1;
  localparam logic [2:0] FACE_BOTTOM = 3'd2;
  localparam logic [2:0] FACE_LEFT   = 3'd3;
  localparam logic [2:0] FACE_RIGHT  = 3'd4;

  // per-item control flags carried down the pipeline
  typedef struct packed {
    logic ovl;    // strict rectangle overlap
    logic ytop;   // moving down, top face facing
    logic xleft;  // moving right, left face facing
  } flags_t;

endpackage

### rtl/core/sbp_axis.sv
// sbp_axis: crossing test of the two leading corners on one axis
// four register stages: offsets, numerator and span distances, products, compares
// depends on sbp_pkg
`timescale 1ns / 1ps
module sbp_axis #(
  parameter int CB = sbp_pkg::COORD_BITS
) (
  input  logic                 clk,
  input  logic signed [CB-1:0] dm,
  input  logic signed [CB-1:0] dc,
  input  logic signed [CB:0]   e,
  input  logic signed [CB:0]   cm,
  input  logic signed [CB:0]   lo,
  input  logic signed [CB:0]   hi,
  input  logic signed [CB:0]   cca,
  input  logic signed [CB:0]   ccb,
  output logic        [CB+1:0] anum,
  output logic        [CB-1:0] aden,
  output logic                 ok
);
  import sbp_pkg::*;

  localparam int W1 = CB + 1;
  localparam int W2 = CB + 2;
  localparam int W3 = CB + 3;
  localparam int PW = 2 * CB + 4;

  // stage 2: corner start points and den magnitude
  logic signed [W2-1:0] p0a, p0b, cmd;
  logic signed [W1-1:0] e2, lo2, hi2;
  logic signed [CB-1:0] dc2;
  logic        [CB-1:0] den2;
  logic                 neg2, nz2;

  always_ff @(posedge clk) begin
    p0a  <= W2'(cca) - W2'(dc);
    p0b  <= W2'(ccb) - W2'(dc);
    cmd  <= W2'(cm) - W2'(dm);
    e2   <= e;
    lo2  <= lo;
    hi2  <= hi;
    dc2  <= dc;
    den2 <= dm[CB-1] ? CB'(-dm) : CB'(dm);
    neg2 <= dm[CB-1];
    nz2  <= (dm != '0);
  end

  // stage 3: signed numerator and span distances
  logic signed [W3-1:0] n3;
  logic signed [W3-1:0] num3, la3, lb3, ha3, hb3;
  logic signed [CB-1:0] dc3;
  logic        [CB-1:0] den3;
  logic                 nz3;

  assign n3 = W3'(e2) - W3'(cmd);

  always_ff @(posedge clk) begin
    num3 <= neg2 ? -n3 : n3;
    anum <= n3[W3-1] ? (W3-1)'(-n3) : (W3-1)'(n3);
    la3  <= W3'(lo2) - W3'(p0a);
    lb3  <= W3'(lo2) - W3'(p0b);
    ha3  <= W3'(hi2) - W3'(p0a);
    hb3  <= W3'(hi2) - W3'(p0b);
    dc3  <= dc2;
    den3 <= den2;
    nz3  <= nz2;
  end

  assign aden = den3;

  // stage 4: cross products
  logic signed [W1-1:0] sden;
  logic signed [PW-1:0] off4, pla4, plb4, pha4, phb4;
  logic                 nz4;

  assign sden = $signed({1'b0, den3});

  always_ff @(posedge clk) begin
    off4 <= PW'(num3) * PW'(dc3);
    pla4 <= PW'(la3) * PW'(sden);
    plb4 <= PW'(lb3) * PW'(sden);
    pha4 <= PW'(ha3) * PW'(sden);
    phb4 <= PW'(hb3) * PW'(sden);
    nz4  <= nz3;
  end

  // stage 5: crossing lies within the inclusive span for either corner
  logic oka, okb;

  assign oka = !(pla4 > off4) && !(off4 > pha4);
  assign okb = !(plb4 > off4) && !(off4 > phb4);

  always_ff @(posedge clk) begin
    ok <= nz4 && (oka || okb);
  end

endmodule

### rtl/core/sbp_resolve.sv
// sbp_resolve: ranks the two axes by crossing fraction and picks the push face
// two compare stages and the output register; depends on sbp_pkg
`timescale 1ns / 1ps
module sbp_resolve #(
  parameter int CB = sbp_pkg::COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic        [CB+1:0] anum_y,
  input  logic        [CB-1:0] aden_y,
  input  logic        [CB+1:0] anum_x,
  input  logic        [CB-1:0] aden_x,
  input  logic                 ok_y,
  input  logic                 ok_x,
  input  sbp_pkg::flags_t      flags,
  input  logic signed [CB-1:0] x,
  input  logic signed [CB-1:0] y,
  input  logic signed [CB-1:0] nyt,
  input  logic signed [CB-1:0] nyb,
  input  logic signed [CB-1:0] nxl,
  input  logic signed [CB-1:0] nxr,
  output logic                 done,
  output logic signed [CB-1:0] new_x,
  output logic signed [CB-1:0] new_y,
  output logic                 overlapping,
  output logic        [2:0]    pushed_face
);
  import sbp_pkg::*;

  localparam int PU = 2 * CB + 2;

  // fraction cross products, |t_y| vs |t_x|
  logic [PU-1:0] py, px;
  logic          xlt;

  always_ff @(posedge clk) begin
    py  <= PU'(anum_y) * PU'(aden_x);
    px  <= PU'(anum_x) * PU'(aden_y);
    xlt <= (px < py);
  end

  // face choice, ties go to the vertical axis
  logic          xnear;
  logic [2:0]    face_next;
  logic signed [CB-1:0] nx_next, ny_next;

  assign xnear = ok_x && (!ok_y || xlt);

  always_comb begin
    nx_next   = x;
    ny_next   = y;
    face_next = FACE_NONE;
    if (flags.ovl) begin
      if (!xnear) begin
        if (ok_y && flags.ytop) begin
          ny_next   = nyt;
          face_next = FACE_TOP;
        end else if (ok_y) begin
          ny_next   = nyb;
          face_next = FACE_BOTTOM;
        end
      end else if (flags.xleft) begin
        nx_next   = nxl;
        face_next = FACE_LEFT;
      end else begin
        nx_next   = nxr;
        face_next = FACE_RIGHT;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    new_x       <= nx_next;
    new_y       <= ny_next;
    overlapping <= flags.ovl;
    pushed_face <= face_next;
  end

endmodule

### rtl/core/swept_box_push_out.sv
// swept_box_push_out: top level, input sums, clamp candidates and pipeline control
// depends on sbp_pkg, sbp_axis, sbp_resolve
`timescale 1ns / 1ps
// One box pair is taken on every clock cycle (busy is always low) and its
// result appears on done once it has passed six register stages: input
// sums and overlap test, corner offsets, crossing numerators, cross
// products, span compares with the axis ranking, and the output register.
// The receiver cannot stall; done is high for one cycle per item and the
// result ports hold their value only for that cycle.
module swept_box_push_out #(
  parameter int COORD_BITS = sbp_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] self_x,
  input  logic signed [COORD_BITS-1:0] self_y,
  input  logic        [COORD_BITS-2:0] self_w,
  input  logic        [COORD_BITS-2:0] self_h,
  input  logic signed [COORD_BITS-1:0] vel_x,
  input  logic signed [COORD_BITS-1:0] vel_y,
  input  logic signed [COORD_BITS-1:0] other_x,
  input  logic signed [COORD_BITS-1:0] other_y,
  input  logic        [COORD_BITS-2:0] other_w,
  input  logic        [COORD_BITS-2:0] other_h,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] new_x,
  output logic signed [COORD_BITS-1:0] new_y,
  output logic                         overlapping,
  output logic        [2:0]            pushed_face
);
  import sbp_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int W1 = CB + 1;
  localparam logic signed [W1-1:0] SMAX = W1'({1'b0, {(CB-1){1'b1}}});
  localparam logic signed [W1-1:0] SMIN = -SMAX - W1'(1);

  assign busy = 1'b0;

  // valid bits for stages one to five
  logic [5:1] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:1], start};
    end
  end

  // widened operands
  logic signed [W1-1:0] x1, y1, w1, h1, ox1, oy1, ow1, oh1;
  logic signed [W1-1:0] xr, yb, oxr, oyb;

  assign x1  = W1'(self_x);
  assign y1  = W1'(self_y);
  assign w1  = $signed({2'b00, self_w});
  assign h1  = $signed({2'b00, self_h});
  assign ox1 = W1'(other_x);
  assign oy1 = W1'(other_y);
  assign ow1 = $signed({2'b00, other_w});
  assign oh1 = $signed({2'b00, other_h});
  assign xr  = x1 + w1;
  assign yb  = y1 + h1;
  assign oxr = ox1 + ow1;
  assign oyb = oy1 + oh1;

  // stage 1: edges, corners, overlap and clamp targets
  logic signed [CB-1:0] vx1, vy1, sx1, sy1;
  logic signed [W1-1:0] ey, cmy, loy, hiy, ccay, ccby;
  logic signed [W1-1:0] ex, cmx, lox, hix, ccax, ccbx;
  logic signed [W1-1:0] topc, botc, leftc, rightc;
  flags_t               fl1;

  always_ff @(posedge clk) begin
    vx1    <= vel_x;
    vy1    <= vel_y;
    sx1    <= self_x;
    sy1    <= self_y;
    ey     <= (vel_y > 0) ? oy1 : oyb;
    cmy    <= (vel_y > 0) ? yb : y1;
    loy    <= ox1;
    hiy    <= oxr;
    ccay   <= x1;
    ccby   <= xr;
    ex     <= (vel_x > 0) ? ox1 : oxr;
    cmx    <= (vel_x > 0) ? xr : x1;
    lox    <= oy1;
    hix    <= oyb;
    ccax   <= y1;
    ccbx   <= yb;
    topc   <= oy1 - h1;
    botc   <= oyb;
    leftc  <= ox1 - w1;
    rightc <= oxr;
    fl1.ovl   <= (x1 < oxr) && (xr > ox1) && (y1 < oyb) && (yb > oy1);
    fl1.ytop  <= (vel_y > 0);
    fl1.xleft <= (vel_x > 0);
  end

  // stage 2: clamped and saturated candidates
  logic signed [W1-1:0] sx1w, sy1w, mt, mb, ml, mr;
  logic signed [CB-1:0] nyt2, nyb2, nxl2, nxr2;

  assign sx1w = W1'(sx1);
  assign sy1w = W1'(sy1);
  assign mt   = (topc < sy1w) ? topc : sy1w;
  assign mb   = (botc > sy1w) ? botc : sy1w;
  assign ml   = (leftc < sx1w) ? leftc : sx1w;
  assign mr   = (rightc > sx1w) ? rightc : sx1w;

  always_comb begin
    nyt2 = (mt < SMIN) ? SMIN[CB-1:0] : mt[CB-1:0];
    nyb2 = (mb > SMAX) ? SMAX[CB-1:0] : mb[CB-1:0];
    nxl2 = (ml < SMIN) ? SMIN[CB-1:0] : ml[CB-1:0];
    nxr2 = (mr > SMAX) ? SMAX[CB-1:0] : mr[CB-1:0];
  end

  // side data line, stages two to five
  logic signed [CB-1:0] dx[2:5], dy[2:5], dnyt[2:5], dnyb[2:5], dnxl[2:5], dnxr[2:5];
  flags_t               dfl[2:5];

  always_ff @(posedge clk) begin
    dx[2]   <= sx1;
    dy[2]   <= sy1;
    dnyt[2] <= nyt2;
    dnyb[2] <= nyb2;
    dnxl[2] <= nxl2;
    dnxr[2] <= nxr2;
    dfl[2]  <= fl1;
    for (int i = 3; i <= 5; i++) begin
      dx[i]   <= dx[i-1];
      dy[i]   <= dy[i-1];
      dnyt[i] <= dnyt[i-1];
      dnyb[i] <= dnyb[i-1];
      dnxl[i] <= dnxl[i-1];
      dnxr[i] <= dnxr[i-1];
      dfl[i]  <= dfl[i-1];
    end
  end

  // per-axis crossing tests
  logic [CB+1:0] anum_y, anum_x;
  logic [CB-1:0] aden_y, aden_x;
  logic          ok_y, ok_x;

  sbp_axis #(.CB(CB)) u_axis_y (
    .clk (clk),
    .dm  (vy1),
    .dc  (vx1),
    .e   (ey),
    .cm  (cmy),
    .lo  (loy),
    .hi  (hiy),
    .cca (ccay),
    .ccb (ccby),
    .anum(anum_y),
    .aden(aden_y),
    .ok  (ok_y)
  );

  sbp_axis #(.CB(CB)) u_axis_x (
    .clk (clk),
    .dm  (vx1),
    .dc  (vy1),
    .e   (ex),
    .cm  (cmx),
    .lo  (lox),
    .hi  (hix),
    .cca (ccax),
    .ccb (ccbx),
    .anum(anum_x),
    .aden(aden_x),
    .ok  (ok_x)
  );

  // face choice and output register
  sbp_resolve #(.CB(CB)) u_resolve (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v[5]),
    .anum_y     (anum_y),
    .aden_y     (aden_y),
    .anum_x     (anum_x),
    .aden_x     (aden_x),
    .ok_y       (ok_y),
    .ok_x       (ok_x),
    .flags      (dfl[5]),
    .x          (dx[5]),
    .y          (dy[5]),
    .nyt        (dnyt[5]),
    .nyb        (dnyb[5]),
    .nxl        (dnxl[5]),
    .nxr        (dnxr[5]),
    .done       (done),
    .new_x      (new_x),
    .new_y      (new_y),
    .overlapping(overlapping),
    .pushed_face(pushed_face)
  );

  // checks
  a_face_needs_overlap: assert property (@(posedge clk) disable iff (rst)
    (done && !overlapping) |-> (pushed_face == FACE_NONE))
    else $error("face pushed without overlap");

  a_face_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (pushed_face == FACE_NONE || pushed_face == FACE_TOP ||
              pushed_face == FACE_BOTTOM || pushed_face == FACE_LEFT ||
              pushed_face == FACE_RIGHT))
    else $error("bad face code");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

### verif/swept_box_push_out_tb.sv
// swept_box_push_out_tb: self-checking testbench for the swept box push-out block
// depends on sbp_pkg and swept_box_push_out; predicts each result with exact wide math
`timescale 1ns / 1ps
module swept_box_push_out_tb;
  import sbp_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [CB-1:0] x, y, vx, vy, ox, oy;
    logic [CB-2:0] w, h, ow, oh;
  } box_pair_t;

  typedef struct {
    logic signed [CB-1:0] nx, ny;
    logic ovl;
    logic [2:0] face;
  } push_t;

  // crossing fraction |num| / den, ok when the corner lands on the edge span
  typedef struct {
    logic ok;
    logic [127:0] num, den;
  } crossing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] self_x = '0, self_y = '0, vel_x = '0, vel_y = '0;
  logic signed [CB-1:0] other_x = '0, other_y = '0;
  logic [CB-2:0] self_w = '0, self_h = '0, other_w = '0, other_h = '0;
  logic done;
  logic signed [CB-1:0] new_x, new_y;
  logic overlapping;
  logic [2:0] pushed_face;

  push_t pending_pushes[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  swept_box_push_out i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .self_x(self_x), .self_y(self_y), .self_w(self_w), .self_h(self_h),
    .vel_x(vel_x), .vel_y(vel_y), .other_x(other_x), .other_y(other_y),
    .other_w(other_w), .other_h(other_h), .done(done), .new_x(new_x),
    .new_y(new_y), .overlapping(overlapping), .pushed_face(pushed_face)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // crossing of one leading corner with the facing edge
  function automatic crossing_t edge_cross(longint e, longint lo, longint hi, longint cm,
                                           longint cc, longint dm, longint dc);
    crossing_t c;
    longint p0c, num, den;
    logic signed [127:0] off;
    c.ok = 1'b0;
    c.num = '0;
    c.den = '0;
    if (dm == 0) return c;
    p0c = cc - dc;
    num = e - (cm - dm);
    den = dm;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    off = 128'(signed'(num)) * 128'(signed'(dc));
    if (128'(signed'(lo - p0c)) * 128'(signed'(den)) > off) return c;
    if (off > 128'(signed'(hi - p0c)) * 128'(signed'(den))) return c;
    c.ok = 1'b1;
    c.num = (num < 0) ? 128'(-num) : 128'(num);
    c.den = 128'(den);
    return c;
  endfunction

  function automatic bit is_nearer(crossing_t a, crossing_t b);
    if (!a.ok) return 1'b0;
    if (!b.ok) return 1'b1;
    return (a.num * b.den) < (b.num * a.den);
  endfunction

  function automatic crossing_t nearest(crossing_t a, crossing_t b);
    return is_nearer(b, a) ? b : a;
  endfunction

  function automatic logic signed [CB-1:0] saturate(longint v);
    longint top, bot;
    top = (64'sd1 <<< (CB - 1)) - 1;
    bot = -top - 1;
    if (v > top) v = top;
    if (v < bot) v = bot;
    return v[CB-1:0];
  endfunction

  function automatic push_t resolve_push(box_pair_t p);
    push_t r;
    longint x, y, w, h, vx, vy, ox, oy, ow, oh, nx, ny;
    crossing_t hy, hx;
    x = p.x; y = p.y; w = p.w; h = p.h; vx = p.vx; vy = p.vy;
    ox = p.ox; oy = p.oy; ow = p.ow; oh = p.oh;
    nx = x; ny = y;
    hy = '{1'b0, '0, '0};
    hx = hy;
    r.ovl = 1'b0;
    r.face = FACE_NONE;
    if (x < ox + ow && x + w > ox && y < oy + oh && y + h > oy) begin
      r.ovl = 1'b1;
      if (vy > 0)
        hy = nearest(edge_cross(oy, ox, ox + ow, y + h, x, vy, vx),
                     edge_cross(oy, ox, ox + ow, y + h, x + w, vy, vx));
      else if (vy < 0)
        hy = nearest(edge_cross(oy + oh, ox, ox + ow, y, x, vy, vx),
                     edge_cross(oy + oh, ox, ox + ow, y, x + w, vy, vx));
      if (vx > 0)
        hx = nearest(edge_cross(ox, oy, oy + oh, x + w, y, vx, vy),
                     edge_cross(ox, oy, oy + oh, x + w, y + h, vx, vy));
      else if (vx < 0)
        hx = nearest(edge_cross(ox + ow, oy, oy + oh, x, y, vx, vy),
                     edge_cross(ox + ow, oy, oy + oh, x, y + h, vx, vy));
      // ties go to the vertical axis
      if (!is_nearer(hx, hy)) begin
        if (hy.ok && vy > 0) begin
          if (oy - h < ny) ny = oy - h;
          r.face = FACE_TOP;
        end else if (hy.ok) begin
          if (oy + oh > ny) ny = oy + oh;
          r.face = FACE_BOTTOM;
        end
      end else if (vx > 0) begin
        if (ox - w < nx) nx = ox - w;
        r.face = FACE_LEFT;
      end else begin
        if (ox + ow > nx) nx = ox + ow;
        r.face = FACE_RIGHT;
      end
    end
    r.nx = saturate(nx);
    r.ny = saturate(ny);
    return r;
  endfunction

  // random gap before an item: mostly none or short, a few long
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // start stays high after the accepting edge until a gap or the end drops it
  task automatic send_item(box_pair_t p);
    self_x <= p.x; self_y <= p.y; self_w <= p.w; self_h <= p.h;
    vel_x <= p.vx; vel_y <= p.vy; other_x <= p.ox; other_y <= p.oy;
    other_w <= p.ow; other_h <= p.oh;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_pushes.push_back(resolve_push(p));
  endtask

  task automatic send_gapped(box_pair_t p);
    idle_gap();
    send_item(p);
  endtask

  function automatic box_pair_t make_pair(longint x, longint y, longint w, longint h,
                                          longint vx, longint vy, longint ox, longint oy,
                                          longint ow, longint oh);
    box_pair_t p;
    p.x = x[CB-1:0]; p.y = y[CB-1:0]; p.w = w[CB-2:0]; p.h = h[CB-2:0];
    p.vx = vx[CB-1:0]; p.vy = vy[CB-1:0]; p.ox = ox[CB-1:0]; p.oy = oy[CB-1:0];
    p.ow = ow[CB-2:0]; p.oh = oh[CB-2:0];
    return p;
  endfunction

  function automatic logic [CB-1:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[CB-1:0];
  endfunction

  // small signed value around a center, scaled by the caller into whole or fractional Q16.16 units
  function automatic longint near_val(longint center, int spread);
    return center + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // pair placed around the other box, not always overlapping, with a plausible motion, coordinates in a few units
  function automatic box_pair_t random_hit();
    longint u, ox, oy, ow, oh;
    u = ($urandom_range(0, 3) == 0) ? 1 : 65536;
    ox = near_val(0, 8) * u;
    oy = near_val(0, 8) * u;
    ow = $urandom_range(0, 8) * u;
    oh = $urandom_range(0, 8) * u;
    return make_pair(ox + near_val(0, 6) * u, oy + near_val(0, 6) * u,
                     $urandom_range(0, 6) * u, $urandom_range(0, 6) * u,
                     near_val(0, 5) * u + $urandom_range(0, 1),
                     near_val(0, 5) * u - $urandom_range(0, 1),
                     ox, oy, ow, oh);
  endfunction

  function automatic box_pair_t random_noise();
    box_pair_t p;
    p.x = rand_word(); p.y = rand_word(); p.vx = rand_word(); p.vy = rand_word();
    p.ox = rand_word(); p.oy = rand_word();
    p.w = (CB-1)'(rand_word()); p.h = (CB-1)'(rand_word());
    p.ow = (CB-1)'(rand_word()); p.oh = (CB-1)'(rand_word());
    return p;
  endfunction

  // directed: each face, no overlap, no crossing, ties, extremes and saturation
  task automatic test_directed();
    longint one, mx, mn, mw;
    one = 65536;
    mx = (64'sd1 <<< (CB - 1)) - 1;
    mn = -mx - 1;
    mw = (64'sd1 <<< (CB - 1)) - 1;
    send_item(make_pair(0, 9 * one, 4 * one, 4 * one, 0, 2 * one, 0, 10 * one,
                        4 * one, 4 * one));
    send_item(make_pair(0, 13 * one, 4 * one, 4 * one, 0, -2 * one, 0, 10 * one,
                        4 * one, 4 * one));
    send_item(make_pair(9 * one, 0, 4 * one, 4 * one, 2 * one, 0, 10 * one, 0,
                        4 * one, 4 * one));
    send_item(make_pair(13 * one, 0, 4 * one, 4 * one, -2 * one, 0, 10 * one, 0,
                        4 * one, 4 * one));
    // touching edges only, no strict overlap
    send_item(make_pair(0, 0, 4 * one, 4 * one, one, one, 4 * one, 0, 4 * one, 4 * one));
    // zero velocity overlap, no crossing
    send_item(make_pair(one, one, 4 * one, 4 * one, 0, 0, 0, 0, 4 * one, 4 * one));
    // diagonal tie goes to vertical
    send_item(make_pair(one, one, 4 * one, 4 * one, 2 * one, 2 * one, 4 * one, 4 * one,
                        4 * one, 4 * one));
    send_item(make_pair(-one, -one, 4 * one, 4 * one, -2 * one, -2 * one, -4 * one,
                        -4 * one, 4 * one, 4 * one));
    // crossing behind the start
    send_item(make_pair(0, one, 4 * one, 4 * one, 0, -one, 0, 0, 4 * one, 8 * one));
    // zero sizes
    send_item(make_pair(0, 0, 0, 0, one, one, 0, 0, 0, 0));
    // extremes and saturating clamps
    send_item(make_pair(mn, mn, mw, mw, mx, mx, mn, mn, mw, mw));
    send_item(make_pair(mx, mx, mw, mw, mn, mn, mx - 4, mx - 4, mw, mw));
    send_item(make_pair(mn, 0, mw, one, mx, 0, mn + one, 0, mw, one));
    send_item(make_pair(mx - one, 0, mw, one, mn, 0, mx - 2 * one, 0, mw, one));
    send_item(make_pair(0, mn + 2, one, mw, 0, mn, 0, mn + 1, one, mw));
    send_item(make_pair(-1, -1, 2, 2, -1, 1, 0, 0, 1, 1));
    send_item(make_pair(mx, mx, 0, 0, mx, mx, mx, mx, 0, 0));
    send_item(make_pair(mn, mx, mw, 0, mn, mx, mn, mn, 0, mw));
  endtask

  task automatic test_random_hits(int count);
    repeat (count) send_gapped(random_hit());
  endtask

  task automatic test_random_noise(int count);
    repeat (count) send_gapped(random_noise());
  endtask

  task automatic test_back_to_back(int count);
    repeat (count) send_item(random_hit());
  endtask

  // compare each result with the oldest expected push
  always @(posedge clk) begin
    push_t exp_push;
    if (!rst && done) begin
      if (pending_pushes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_push = pending_pushes.pop_front();
        if (new_x !== exp_push.nx || new_y !== exp_push.ny ||
            overlapping !== exp_push.ovl || pushed_face !== exp_push.face) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h ovl=%b face=%0d got x=%h y=%h ovl=%b face=%0d",
                     exp_push.nx, exp_push.ny, exp_push.ovl, exp_push.face,
                     new_x, new_y, overlapping, pushed_face);
        end
      end
    end
  end

  // watchdog over cycles with no item moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("swept_box_push_out_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_hits(420);
    test_back_to_back(80);
    test_random_noise(130);
    start <= 1'b0;
    while (pending_pushes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_pushes.size() == 0) begin
      $display("swept_box_push_out_tb passed");
    end else begin
      $display("swept_box_push_out_tb failed");
    end
    $finish;
  end

endmodule
